@@ hw/rtl/tank_level_controller_top_assert.svh @@
// ----------------------------------------------------------------------------
// Tank level controller assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TANK_LEVEL_CONTROLLER_TOP_ASSERT_SVH
`define TANK_LEVEL_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tlc_pkg.sv @@
// ----------------------------------------------------------------------------
// Tank level controller package
// Request and result types, register codes and shared constants.
// ----------------------------------------------------------------------------
package tlc_pkg;

  // Fixed field widths and counts.
  localparam int TANK_MAX     = 3;
  localparam int BUTTON_COUNT = 4;
  localparam int SAMPLE_W     = 16;
  localparam int DT_W         = 16;
  localparam int TIMER_W      = 20;
  localparam int THRESH_W     = 16;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // Default configuration of the design.
  localparam int RING_LENGTH_DEF = 100;
  localparam int TANK_COUNT_DEF  = 3;

  // Register reset values.
  localparam logic [THRESH_W-1:0] THRESH_RESET   = 16'd52428;
  localparam logic [TIMER_W-1:0]  DEBOUNCE_RESET = 20'd50000;
  localparam logic [TIMER_W-1:0]  TIMER_MAX      = '1;

  // Button positions in the raw level word.
  localparam int MODE_BTN = 0;

  // Tank 0 is driven by the pump button, tank 1 by valve 1, tank 2 by valve 2.
  localparam logic [1:0] TANK_BUTTON [TANK_MAX] = '{2'd3, 2'd1, 2'd2};

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_LEVEL_THRESHOLD = 1'b0,
    REG_DEBOUNCE_US     = 1'b1
  } reg_idx_t;

  // One control-loop pass.
  typedef struct packed {
    logic [SAMPLE_W-1:0]     level_sample_0;
    logic [SAMPLE_W-1:0]     level_sample_1;
    logic [SAMPLE_W-1:0]     level_sample_2;
    logic [BUTTON_COUNT-1:0] button_levels;
    logic [DT_W-1:0]         elapsed_us;
  } in_item_t;

  // Result of one pass.
  typedef struct packed {
    logic [TANK_MAX-1:0] actuators_on;
    logic                manual_active;
    logic [SAMPLE_W-1:0] level_avg_0;
    logic [SAMPLE_W-1:0] level_avg_1;
    logic [SAMPLE_W-1:0] level_avg_2;
  } out_item_t;

endpackage

@@ hw/rtl/tank_level_controller_top.sv @@
// ----------------------------------------------------------------------------
// Tank level controller
// Button debounce, per-tank sample rings with running sums, and actuator drive.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output is not stalled, and
// registers it through stage one, stage two and the output register before
// raising out_valid for its result. Debounce, mode and manual toggles resolve
// in the accept cycle; the sample ring is a single memory with one row per
// ring slot holding all tanks, read at acceptance and written back as stage
// one drains, so one read-modify-write per request sets the rate of one
// request per cycle. The averages come from a reciprocal multiply in the last
// stage. The ring is not cleared: until it has wrapped, old slots read as zero.
`include "tank_level_controller_top_assert.svh"

module tank_level_controller_top #(
  parameter int RING_LENGTH = tlc_pkg::RING_LENGTH_DEF,
  parameter int TANK_COUNT  = tlc_pkg::TANK_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tlc_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tlc_pkg::out_item_t           out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tlc_pkg::*;

  // Derived sizes.
  localparam int RING_AW   = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;
  localparam int RING_LOG  = $clog2(RING_LENGTH);
  localparam int SUM_W     = SAMPLE_W + RING_LOG;
  localparam int DIV_SHIFT = SUM_W + RING_LOG;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int ROW_W     = TANK_COUNT * SAMPLE_W;
  localparam longint RECIP_L =
    ((longint'(1) << DIV_SHIFT) + longint'(RING_LENGTH) - 1) / longint'(RING_LENGTH);
  localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_LENGTH - 1);
  localparam logic [SUM_W-1:0]   THR_SCALED_RESET = SUM_W'(THRESH_RESET * RING_LENGTH);

  // Configuration registers.
  logic [THRESH_W-1:0] threshold_r;
  logic [SUM_W-1:0]    thr_scaled_r;
  logic [TIMER_W-1:0]  debounce_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  // Debounce and mode state.
  logic [TIMER_W-1:0]      timer_r   [BUTTON_COUNT];
  logic [TIMER_W-1:0]      timer_nxt [BUTTON_COUNT];
  logic [TIMER_W:0]        timer_sum [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] stable_r, stable_nxt;
  logic [BUTTON_COUNT-1:0] prev_r, prev_nxt;
  logic [BUTTON_COUNT-1:0] press_r, press_nxt;
  logic [BUTTON_COUNT-1:0] handled_r, handled_nxt;
  logic                    manual_r, manual_nxt;
  logic [TANK_MAX-1:0]     toggle_nxt;

  // Ring position and sample memory.
  logic [RING_AW-1:0] ring_pos_r;
  logic               wrapped_r;
  logic [ROW_W-1:0]   ring_mem [RING_LENGTH];
  logic [ROW_W-1:0]   rd_row_r;
  logic [ROW_W-1:0]   fwd_row_r;
  logic [ROW_W-1:0]   wr_row;
  logic [ROW_W-1:0]   old_row;
  logic               mem_we;

  // Running sums and actuator drive.
  logic [SUM_W-1:0]    sums_r  [TANK_COUNT];
  logic [SUM_W-1:0]    sum_upd [TANK_COUNT];
  logic [TANK_MAX-1:0] cmp_bits;
  logic [TANK_MAX-1:0] drive_r, drive_upd;

  // Stage one: accepted request waiting for its ring row.
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r [TANK_COUNT];
  logic                s1_auto_r;
  logic                s1_manual_r;
  logic [TANK_MAX-1:0] s1_toggle_r;
  logic [RING_AW-1:0]  s1_addr_r;
  logic                s1_old_valid_r;
  logic                s1_fwd_r;

  // Stage two: updated sums ready for averaging.
  logic                s2_valid_r;
  logic [SUM_W-1:0]    s2_sum_r [TANK_COUNT];
  logic [TANK_MAX-1:0] s2_drive_r;
  logic                s2_manual_r;

  // Output register.
  logic                out_valid_r;
  out_item_t           out_r;
  logic [SAMPLE_W-1:0] avg_w [TANK_MAX];

  // Pipeline flow.
  logic out_go, s2_go, s1_go, acc;

  assign out_go   = !out_valid_r || out_ready;
  assign s2_go    = !s2_valid_r || out_go;
  assign s1_go    = !s1_valid_r || s2_go;
  assign in_ready = s1_go;
  assign acc      = in_valid && s1_go;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (cfg_idx)
      REG_LEVEL_THRESHOLD: prdata = PDATA_W'(threshold_r);
      REG_DEBOUNCE_US:     prdata = PDATA_W'(debounce_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESH_RESET;
      thr_scaled_r <= THR_SCALED_RESET;
      debounce_r   <= DEBOUNCE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LEVEL_THRESHOLD: begin
          threshold_r  <= pwdata[THRESH_W-1:0];
          thr_scaled_r <= SUM_W'(pwdata[THRESH_W-1:0] * RING_LENGTH);
        end
        REG_DEBOUNCE_US: begin
          debounce_r <= pwdata[TIMER_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Debounce, mode switch and manual toggles for the request at the input.
  always_comb begin
    stable_nxt  = stable_r;
    press_nxt   = press_r;
    handled_nxt = handled_r;
    prev_nxt    = prev_r;
    manual_nxt  = manual_r;
    toggle_nxt  = '0;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      timer_sum[b] = {1'b0, timer_r[b]} + (TIMER_W + 1)'(in_item.elapsed_us);
      timer_nxt[b] = timer_sum[b][TIMER_W] ? TIMER_MAX : timer_sum[b][TIMER_W-1:0];
      if (manual_r || b == MODE_BTN) begin
        if (in_item.button_levels[b] != prev_r[b]) begin
          timer_nxt[b] = '0;
        end
        if (timer_nxt[b] >= debounce_r) begin
          if (in_item.button_levels[b] != stable_r[b]) begin
            stable_nxt[b]  = in_item.button_levels[b];
            handled_nxt[b] = 1'b0;
          end
          press_nxt[b] = !stable_nxt[b] && !handled_nxt[b];
        end
        prev_nxt[b] = in_item.button_levels[b];
      end
    end
    if (press_nxt[MODE_BTN]) begin
      manual_nxt            = !manual_r;
      handled_nxt[MODE_BTN] = 1'b1;
    end else if (manual_r) begin
      for (int t = 0; t < TANK_COUNT; t++) begin
        if (press_nxt[TANK_BUTTON[t]]) begin
          toggle_nxt[t]               = 1'b1;
          handled_nxt[TANK_BUTTON[t]] = 1'b1;
        end
      end
    end
  end

  // Control state advances with every accepted request; the ring position only in automatic mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        timer_r[b] <= '0;
      end
      stable_r   <= '1;
      prev_r     <= '1;
      press_r    <= '0;
      handled_r  <= '0;
      manual_r   <= 1'b0;
      ring_pos_r <= '0;
      wrapped_r  <= 1'b0;
    end else if (acc) begin
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        timer_r[b] <= timer_nxt[b];
      end
      stable_r  <= stable_nxt;
      prev_r    <= prev_nxt;
      press_r   <= press_nxt;
      handled_r <= handled_nxt;
      manual_r  <= manual_nxt;
      if (!manual_r) begin
        if (ring_pos_r == RING_LAST) begin
          ring_pos_r <= '0;
          wrapped_r  <= 1'b1;
        end else begin
          ring_pos_r <= ring_pos_r + 1'b1;
        end
      end
    end
  end

  // Stage one valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_go) begin
      s1_valid_r <= acc;
    end
  end

  // Stage one payload, captured at acceptance.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sample_r[0] <= in_item.level_sample_0;
      if (TANK_COUNT > 1) begin
        s1_sample_r[TANK_COUNT > 1 ? 1 : 0] <= in_item.level_sample_1;
      end
      if (TANK_COUNT > 2) begin
        s1_sample_r[TANK_COUNT > 2 ? 2 : 0] <= in_item.level_sample_2;
      end
      s1_auto_r      <= !manual_r;
      s1_manual_r    <= manual_nxt;
      s1_toggle_r    <= toggle_nxt;
      s1_addr_r      <= ring_pos_r;
      s1_old_valid_r <= wrapped_r;
      s1_fwd_r       <= mem_we && (s1_addr_r == ring_pos_r);
      fwd_row_r      <= wr_row;
    end
  end

  // Ring memory: read the slot at acceptance, write it back as stage one drains.
  assign mem_we = s1_valid_r && s1_auto_r && s2_go;

  always_ff @(posedge clk) begin
    if (acc && !manual_r) begin
      rd_row_r <= ring_mem[ring_pos_r];
    end
    if (mem_we) begin
      ring_mem[s1_addr_r] <= wr_row;
    end
  end

  // Old slot contents: forwarded write, stored row, or zero before first write.
  assign old_row = s1_fwd_r ? fwd_row_r : (s1_old_valid_r ? rd_row_r : '0);

  // Per-tank sum update and threshold compare.
  for (genvar t = 0; t < TANK_MAX; t++) begin : g_tank
    if (t < TANK_COUNT) begin : g_on
      assign wr_row[t*SAMPLE_W +: SAMPLE_W] = s1_sample_r[t];
      assign sum_upd[t] = sums_r[t] - SUM_W'(old_row[t*SAMPLE_W +: SAMPLE_W])
                          + SUM_W'(s1_sample_r[t]);
      assign cmp_bits[t] = sum_upd[t] < thr_scaled_r;
    end else begin : g_off
      assign cmp_bits[t] = 1'b0;
    end
  end

  assign drive_upd = s1_auto_r ? cmp_bits : (drive_r ^ s1_toggle_r);

  // Sums and drive commit as stage one drains.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TANK_COUNT; t++) begin
        sums_r[t] <= '0;
      end
      drive_r <= '0;
    end else if (s1_valid_r && s2_go) begin
      if (s1_auto_r) begin
        for (int t = 0; t < TANK_COUNT; t++) begin
          sums_r[t] <= sum_upd[t];
        end
      end
      drive_r <= drive_upd;
    end
  end

  // Stage two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_go) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_go) begin
      for (int t = 0; t < TANK_COUNT; t++) begin
        s2_sum_r[t] <= s1_auto_r ? sum_upd[t] : sums_r[t];
      end
      s2_drive_r  <= drive_upd;
      s2_manual_r <= s1_manual_r;
    end
  end

  // Averages: exact division by the ring length through a reciprocal multiply.
  for (genvar t = 0; t < TANK_MAX; t++) begin : g_avg
    if (t < TANK_COUNT) begin : g_on
      logic [PROD_W-1:0] prod;
      assign prod     = PROD_W'(s2_sum_r[t]) * PROD_W'(RECIP);
      assign avg_w[t] = prod[DIV_SHIFT +: SAMPLE_W];
    end else begin : g_off
      assign avg_w[t] = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_go) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_go) begin
      out_r.actuators_on  <= s2_drive_r;
      out_r.manual_active <= s2_manual_r;
      out_r.level_avg_0   <= avg_w[0];
      out_r.level_avg_1   <= avg_w[1];
      out_r.level_avg_2   <= avg_w[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Checks.
  `TLC_ASSERT_NEXT(a_accept_loads_stage, in_valid && in_ready, s1_valid_r, "request lost")
  `TLC_ASSERT_NOW(a_ring_pos_range, 1'b1, ring_pos_r <= RING_LAST, "ring position out of range")
  `TLC_ASSERT_NOW(a_write_only_auto, mem_we, s1_auto_r, "ring written in manual mode")
  `TLC_ASSERT_NEXT(a_manual_holds_ring, in_valid && in_ready && manual_r, $stable(ring_pos_r), "ring moved")

endmodule
